[hdl/msa_pkg.sv]
// Shared types and codes for the multiple-stacks-in-one-array block.
package msa_pkg;

	// Operation codes on the input item.
	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_POP  = 2'd1;
	localparam logic [1:0] KIND_LIST = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd3;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BAD      = 2'd3
	} msa_status_t;

	// Commands handed from the front to the back.
	typedef enum logic [1:0] {
		OP_PUSH,
		OP_POP,
		OP_LIST,
		OP_REPLY
	} msa_op_t;

	typedef struct packed {
		msa_op_t     op;
		msa_status_t status;
	} msa_ctrl_t;

	// Back-end sequencer states.
	typedef enum logic {
		BK_IDLE,
		BK_WAIT
	} msa_back_state_t;

endpackage

[hdl/msa_front.sv]
// Front end: configuration, fill levels and classification of each input item.
module msa_front #(
	parameter int TOTAL_ENTRIES = 64,
	parameter int MAX_STACKS    = 8,
	parameter int DATA_WIDTH    = 32,
	parameter int QW            = $bits(msa_pkg::msa_ctrl_t) + $clog2(TOTAL_ENTRIES)
	                              + $clog2(TOTAL_ENTRIES + 1) + DATA_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [3:0]    cfg_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_kind,
	input  logic [2:0]    in_stack,
	input  logic [31:0]   in_value,
	output logic          q_valid,
	input  logic          q_ready,
	output logic [QW-1:0] q_data
);

	localparam int AW    = $clog2(TOTAL_ENTRIES);
	localparam int CNT_W = $clog2(TOTAL_ENTRIES + 1);
	localparam int SC_W  = $clog2(MAX_STACKS + 1);
	localparam int SI_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
	localparam int PW    = CNT_W + 4;

	// Segment length for every legal stack count, worked out at elaboration.
	logic [CNT_W-1:0] seg_tab [0:MAX_STACKS];
	for (genvar c = 0; c <= MAX_STACKS; c++) begin : g_seg
		localparam int SEG = TOTAL_ENTRIES / ((c == 0) ? 1 : c);
		assign seg_tab[c] = CNT_W'(SEG);
	end

	logic [SC_W-1:0]  count_q;
	logic [CNT_W-1:0] seg_q;
	logic [CNT_W-1:0] fill_q [MAX_STACKS];

	logic [7:0]        cfg8;
	logic [SC_W-1:0]   cfg_clamped;
	logic [7:0]        sn8;
	logic [7:0]        cnt8;
	logic              bad;
	logic [SI_W-1:0]   sn_idx;
	logic [CNT_W-1:0]  lvl;
	logic [PW-1:0]     prod;
	logic [CNT_W-1:0]  base;
	logic [CNT_W:0]    sum;
	logic              last_stk;
	logic              full;
	logic              empty;
	logic [63:0]       v64;
	msa_pkg::msa_ctrl_t ctrl;
	logic [AW-1:0]     addr;
	logic [CNT_W-1:0]  cnt;
	logic              do_inc;
	logic              do_dec;
	logic              accept;

	assign cfg_ready = 1'b1;

	// Clamp the written stack count into 1..MAX_STACKS.
	always_comb begin
		cfg8 = 8'(cfg_data);
		if (cfg8 == 8'd0) begin
			cfg_clamped = SC_W'(1);
		end else if (cfg8 > 8'(MAX_STACKS)) begin
			cfg_clamped = SC_W'(MAX_STACKS);
		end else begin
			cfg_clamped = SC_W'(cfg_data);
		end
	end

	// Locate the addressed segment and check its bounds.
	always_comb begin
		sn8      = 8'(in_stack);
		cnt8     = 8'(count_q);
		bad      = (sn8 >= cnt8) || (sn8 >= 8'(MAX_STACKS));
		sn_idx   = SI_W'(in_stack);
		lvl      = fill_q[sn_idx];
		prod     = PW'(seg_q) * PW'(in_stack);
		base     = prod[CNT_W-1:0];
		sum      = {1'b0, base} + {1'b0, lvl};
		last_stk = (sn8 + 8'd1 == cnt8);
		full     = last_stk ? (sum >= (CNT_W + 1)'(TOTAL_ENTRIES)) : (lvl >= seg_q);
		empty    = (lvl == '0);
		v64      = {32'b0, in_value};
	end

	// Classify the item into a back-end command.
	always_comb begin
		ctrl.op     = msa_pkg::OP_REPLY;
		ctrl.status = msa_pkg::ST_OK;
		addr        = AW'(sum - (CNT_W + 1)'(1));
		cnt         = CNT_W'(1);
		do_inc      = 1'b0;
		do_dec      = 1'b0;
		if (bad) begin
			ctrl.status = msa_pkg::ST_BAD;
		end else begin
			case (in_kind)
				msa_pkg::KIND_PUSH: begin
					if (full) begin
						ctrl.status = msa_pkg::ST_OVERFLOW;
					end else begin
						ctrl.op = msa_pkg::OP_PUSH;
						addr    = AW'(sum);
						do_inc  = 1'b1;
					end
				end
				msa_pkg::KIND_POP: begin
					if (empty) begin
						ctrl.status = msa_pkg::ST_EMPTY;
					end else begin
						ctrl.op = msa_pkg::OP_POP;
						do_dec  = 1'b1;
					end
				end
				msa_pkg::KIND_LIST: begin
					if (empty) begin
						ctrl.status = msa_pkg::ST_EMPTY;
					end else begin
						ctrl.op = msa_pkg::OP_LIST;
						cnt     = lvl;
					end
				end
				default: begin
					ctrl.op = msa_pkg::OP_REPLY;
				end
			endcase
		end
	end

	// Unused kinds are taken and dropped; everything else goes to the queue.
	assign in_ready = q_ready;
	assign q_valid  = in_valid && (in_kind != msa_pkg::KIND_NONE);
	assign q_data   = {v64[DATA_WIDTH-1:0], cnt, addr, ctrl};
	assign accept   = in_valid && in_ready && (in_kind != msa_pkg::KIND_NONE);

	// Hold the stack count and segment length; empty all stacks on a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= SC_W'(1);
			seg_q   <= CNT_W'(TOTAL_ENTRIES);
			for (int i = 0; i < MAX_STACKS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_clamped;
			seg_q   <= seg_tab[cfg_clamped];
			for (int i = 0; i < MAX_STACKS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (accept && !bad) begin
			if (do_inc) begin
				fill_q[sn_idx] <= lvl + CNT_W'(1);
			end else if (do_dec) begin
				fill_q[sn_idx] <= lvl - CNT_W'(1);
			end
		end
	end

endmodule

[hdl/msa_queue.sv]
// Two-entry command queue between the front and back ends.
module msa_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       used_q;
	logic             push;
	logic             pop;

	assign in_ready  = (used_q != 2'd2);
	assign out_valid = (used_q != 2'd0);
	assign out_data  = slot_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// Store an incoming command.
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_data;
		end
	end

	// Advance pointers and the occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			used_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   used_q <= used_q + 2'd1;
				2'b01:   used_q <= used_q - 2'd1;
				default: used_q <= used_q;
			endcase
		end
	end

endmodule

[hdl/msa_back.sv]
// Back end: item memory, read walk for pop and list, and the result register.
module msa_back #(
	parameter int TOTAL_ENTRIES = 64,
	parameter int DATA_WIDTH    = 32,
	parameter int QW            = $bits(msa_pkg::msa_ctrl_t) + $clog2(TOTAL_ENTRIES)
	                              + $clog2(TOTAL_ENTRIES + 1) + DATA_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  logic [QW-1:0] q_data,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    out_status,
	output logic [31:0]   out_value,
	output logic          out_last
);

	localparam int AW    = $clog2(TOTAL_ENTRIES);
	localparam int CNT_W = $clog2(TOTAL_ENTRIES + 1);

	msa_pkg::msa_ctrl_t       cmd_ctrl;
	logic [AW-1:0]            cmd_addr;
	logic [CNT_W-1:0]         cmd_cnt;
	logic [DATA_WIDTH-1:0]    cmd_value;

	logic [DATA_WIDTH-1:0]    mem [TOTAL_ENTRIES];
	logic [DATA_WIDTH-1:0]    rd_data_q;

	msa_pkg::msa_back_state_t state_q;
	msa_pkg::msa_back_state_t state_d;
	logic [AW-1:0]            addr_q;
	logic [CNT_W-1:0]         remain_q;

	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic [31:0]              value_q;
	logic                     last_q;

	logic                     out_free;
	logic                     mem_we;
	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic                     start_walk;
	logic                     step_walk;
	logic                     load_out;
	logic [1:0]               load_status;
	logic                     load_data;
	logic                     load_last;
	logic [63:0]              wide;

	assign {cmd_value, cmd_cnt, cmd_addr, cmd_ctrl} = q_data;
	assign out_free = !out_valid_q || out_ready;
	assign wide     = 64'(signed'(rd_data_q));

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			msa_pkg::BK_IDLE: begin
				if (q_valid && out_free &&
				    (cmd_ctrl.op == msa_pkg::OP_POP || cmd_ctrl.op == msa_pkg::OP_LIST)) begin
					state_d = msa_pkg::BK_WAIT;
				end
			end
			msa_pkg::BK_WAIT: begin
				if (out_free && remain_q == CNT_W'(1)) begin
					state_d = msa_pkg::BK_IDLE;
				end
			end
			default: state_d = msa_pkg::BK_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		q_ready     = 1'b0;
		mem_we      = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = cmd_addr;
		start_walk  = 1'b0;
		step_walk   = 1'b0;
		load_out    = 1'b0;
		load_status = msa_pkg::ST_OK;
		load_data   = 1'b0;
		load_last   = 1'b1;
		case (state_q)
			msa_pkg::BK_IDLE: begin
				if (q_valid && out_free) begin
					q_ready = 1'b1;
					case (cmd_ctrl.op)
						msa_pkg::OP_PUSH: begin
							mem_we   = 1'b1;
							load_out = 1'b1;
						end
						msa_pkg::OP_POP, msa_pkg::OP_LIST: begin
							rd_en      = 1'b1;
							start_walk = 1'b1;
						end
						default: begin
							load_out    = 1'b1;
							load_status = cmd_ctrl.status;
						end
					endcase
				end
			end
			msa_pkg::BK_WAIT: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_data = 1'b1;
					load_last = (remain_q == CNT_W'(1));
					if (remain_q != CNT_W'(1)) begin
						rd_en     = 1'b1;
						rd_addr   = addr_q - AW'(1);
						step_walk = 1'b1;
					end
				end
			end
			default: begin
				q_ready = 1'b0;
			end
		endcase
	end

	// Item memory: write on push, registered read for the walk.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[cmd_addr] <= cmd_value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Walk address and remaining item count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= msa_pkg::BK_IDLE;
			addr_q   <= '0;
			remain_q <= '0;
		end else begin
			state_q <= state_d;
			if (start_walk) begin
				addr_q   <= cmd_addr;
				remain_q <= cmd_cnt;
			end else if (step_walk) begin
				addr_q   <= addr_q - AW'(1);
				remain_q <= remain_q - CNT_W'(1);
			end
		end
	end

	// Result register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= load_status;
			value_q  <= load_data ? wide[31:0] : 32'd0;
			last_q   <= load_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_value  = value_q;
	assign out_last   = last_q;

endmodule

[hdl/multiple_stacks_in_one_array_top.sv]
// Top level of the multiple-stacks-in-one-array block.
//
// Several stacks share one memory of TOTAL_ENTRIES words, split into
// stack_count equal segments, the last one running to the end of memory.
// Input items arrive on s_*: s_tuser is the operation (push, pop, list,
// unused code ignored), s_tdata the stack number and push value. Results
// leave on m_*: m_tuser is the status, m_tdata the popped or listed item,
// m_tlast marks the final result of an item's run.
// cfg_* writes the stack count (clamped to 1..MAX_STACKS) and empties every
// stack; cfg_ready is always high. Write it only while the block is idle.
// The front end classifies an item in the cycle it is accepted and keeps
// the fill levels; a two-entry command queue feeds the back end, which owns
// the memory. A push or error reply loads the result register directly; a pop
// does a registered memory read, then loads the result; a list reads and
// loads one item after another, read down from the top. The front accepts
// one item per cycle while the queue has room. A stalled m_tready holds
// the result register, which in turn stalls the back end and, once the
// queue fills, s_tready.
// After reset all stacks are empty and there is one stack.
module multiple_stacks_in_one_array_top #(
	parameter int TOTAL_ENTRIES = 64,
	parameter int MAX_STACKS    = 8,
	parameter int DATA_WIDTH    = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,    // stack_count
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,     // [2:0] stack_number, [34:3] push_value, zero fill
	input  logic [1:0]  s_tuser,     // [1:0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // [31:0] read_value
	output logic [1:0]  m_tuser,     // [1:0] status
	output logic        m_tlast
);

	localparam int QW = $bits(msa_pkg::msa_ctrl_t) + $clog2(TOTAL_ENTRIES)
	                    + $clog2(TOTAL_ENTRIES + 1) + DATA_WIDTH;

	logic          q_in_valid;
	logic          q_in_ready;
	logic [QW-1:0] q_in_data;
	logic          q_out_valid;
	logic          q_out_ready;
	logic [QW-1:0] q_out_data;

	msa_front #(
		.TOTAL_ENTRIES(TOTAL_ENTRIES),
		.MAX_STACKS   (MAX_STACKS),
		.DATA_WIDTH   (DATA_WIDTH),
		.QW           (QW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (s_tuser),
		.in_stack (s_tdata[2:0]),
		.in_value (s_tdata[34:3]),
		.q_valid  (q_in_valid),
		.q_ready  (q_in_ready),
		.q_data   (q_in_data)
	);

	msa_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_in_valid),
		.in_ready (q_in_ready),
		.in_data  (q_in_data),
		.out_valid(q_out_valid),
		.out_ready(q_out_ready),
		.out_data (q_out_data)
	);

	msa_back #(
		.TOTAL_ENTRIES(TOTAL_ENTRIES),
		.DATA_WIDTH   (DATA_WIDTH),
		.QW           (QW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_out_valid),
		.q_ready   (q_out_ready),
		.q_data    (q_out_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_status(m_tuser),
		.out_value (m_tdata),
		.out_last  (m_tlast)
	);

endmodule

[dv/tb.sv]
// Self-checking testbench for the shared-memory multi-stack block: random and directed ops.
module tb;

	localparam int TOTAL_ENTRIES = 64;
	localparam int MAX_STACKS    = 8;
	localparam int DATA_WIDTH    = 32;
	localparam int AW            = $clog2(TOTAL_ENTRIES);
	localparam int PHASE_OPS     = 67;
	localparam int HOLD_CYCLES   = 300;
	localparam int QUIET_LIMIT   = 3000;
	localparam int TAIL_CYCLES   = 8;

	typedef struct {
		logic [1:0]  kind;
		logic [2:0]  stack;
		logic [31:0] value;
	} stack_op_t;

	typedef struct {
		msa_pkg::msa_status_t status;
		logic [31:0]          value;
		logic                 last;
	} stack_reply_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data  = 4'd0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = 40'd0;     // [2:0] stack_number, [34:3] push_value, zero fill
	logic [1:0]  s_tuser   = 2'd0;      // [1:0] kind
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;               // [31:0] read_value
	logic [1:0]  m_tuser;               // [1:0] status
	logic        m_tlast;

	// Ops waiting to be offered, and replies the stacks must still give
	stack_op_t    op_queue[$];
	stack_reply_t pending_replies[$];
	stack_op_t    offer;
	logic         offer_live = 1'b0;

	// Shadow copy of the stacks
	logic [31:0] store_q [TOTAL_ENTRIES];
	logic [6:0]  level_q [MAX_STACKS];
	int unsigned stacks_n = 1;

	int snd_idle     = 24;
	int rcv_idle     = 87;
	logic hold_req   = 1'b0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int err_count    = 0;

	multiple_stacks_in_one_array_top #(
		.TOTAL_ENTRIES(TOTAL_ENTRIES),
		.MAX_STACKS   (MAX_STACKS),
		.DATA_WIDTH   (DATA_WIDTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	function automatic stack_op_t make_op(input logic [1:0] kind, input logic [2:0] stack,
			input logic [31:0] value);
		stack_op_t op;
		op.kind  = kind;
		op.stack = stack;
		op.value = value;
		return op;
	endfunction

	function automatic void add_reply(input msa_pkg::msa_status_t st, input logic [31:0] value,
			input logic last);
		stack_reply_t r;
		r.status = st;
		r.value  = value;
		r.last   = last;
		pending_replies.push_back(r);
	endfunction

	// Apply one op to the shadow stacks and queue the replies it causes
	function automatic void apply_stack_op(input stack_op_t op);
		int unsigned seg, base, lim, lvl;
		int k;
		if (op.kind == msa_pkg::KIND_NONE)
			return;
		if (op.stack >= stacks_n) begin
			add_reply(msa_pkg::ST_BAD, 32'd0, 1'b1);
			return;
		end
		seg  = TOTAL_ENTRIES / stacks_n;
		base = seg * op.stack;
		lim  = (op.stack + 1 == stacks_n) ? TOTAL_ENTRIES : base + seg;
		lvl  = level_q[op.stack];
		if (op.kind == msa_pkg::KIND_PUSH) begin
			if (base + lvl >= lim) begin
				add_reply(msa_pkg::ST_OVERFLOW, 32'd0, 1'b1);
			end else begin
				store_q[AW'(base + lvl)] = op.value;
				level_q[op.stack] = 7'(lvl + 1);
				add_reply(msa_pkg::ST_OK, 32'd0, 1'b1);
			end
		end else if (lvl == 0) begin
			add_reply(msa_pkg::ST_EMPTY, 32'd0, 1'b1);
		end else if (op.kind == msa_pkg::KIND_POP) begin
			// Items are full width here, so no sign extension is needed
			add_reply(msa_pkg::ST_OK, store_q[AW'(base + lvl - 1)], 1'b1);
			level_q[op.stack] = 7'(lvl - 1);
		end else begin
			for (k = 0; k < lvl; k++)
				add_reply(msa_pkg::ST_OK, store_q[AW'(base + lvl - 1 - k)], (k + 1 == lvl));
		end
	endfunction

	task automatic report_mismatch(input string what);
		if (err_count < 100)
			$display("tb: mismatch at %0t: %s", $realtime, what);
		err_count++;
	endtask

	// Write the stack count and empty the shadow stacks
	task automatic write_stack_count(input logic [3:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		stacks_n = (v == 0) ? 1 : ((v > MAX_STACKS) ? MAX_STACKS : v);
		foreach (level_q[i])
			level_q[i] = 7'd0;
	endtask

	// Hold until every op is taken and every reply has come, then let the pipe settle
	task automatic wait_idle();
		int k;
		while (op_queue.size() != 0 || offer_live || pending_replies.size() != 0)
			@(posedge clk);
		for (k = 0; k < TAIL_CYCLES; k++)
			@(posedge clk);
	endtask

	// Offer ops; predict each one when it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			s_tdata    <= 40'd0;
			s_tuser    <= 2'd0;
			offer_live = 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				apply_stack_op(offer);
				offer_live = 1'b0;
			end
			if (!s_tvalid || s_tready) begin
				if (op_queue.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
					offer = op_queue.pop_front();
					offer_live = 1'b1;
					s_tvalid <= 1'b1;
					s_tuser  <= offer.kind;
					s_tdata  <= {5'd0, offer.value, offer.stack};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Drive ready: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready  <= 1'b0;
			hold_left <= 0;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	// Check each reply against the oldest prediction
	always @(posedge clk) begin
		stack_reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("unexpected reply status %0d data %h last %0b",
					m_tuser, m_tdata, m_tlast));
			end else begin
				want = pending_replies.pop_front();
				if (m_tuser !== want.status)
					report_mismatch($sformatf("status %0d, want %0d", m_tuser, want.status));
				if (m_tdata !== want.value)
					report_mismatch($sformatf("read value %h, want %h", m_tdata, want.value));
				if (m_tlast !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
			end
		end
	end

	// Stop the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		stack_op_t op;
		int p, made, roll, sn, cap, k, seg;
		logic [3:0] cnt;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: one stack after reset, empty cases, extreme values, bad numbers
		op_queue.push_back(make_op(msa_pkg::KIND_POP,  3'd0, 32'd0));
		op_queue.push_back(make_op(msa_pkg::KIND_LIST, 3'd0, 32'd0));
		op_queue.push_back(make_op(msa_pkg::KIND_PUSH, 3'd0, 32'h8000_0000));
		op_queue.push_back(make_op(msa_pkg::KIND_PUSH, 3'd0, 32'h7fff_ffff));
		op_queue.push_back(make_op(msa_pkg::KIND_PUSH, 3'd0, 32'h0000_0000));
		op_queue.push_back(make_op(msa_pkg::KIND_PUSH, 3'd0, 32'hffff_ffff));
		op_queue.push_back(make_op(msa_pkg::KIND_LIST, 3'd0, 32'd0));
		op_queue.push_back(make_op(msa_pkg::KIND_POP,  3'd1, 32'd0));
		op_queue.push_back(make_op(msa_pkg::KIND_LIST, 3'd7, 32'hffff_ffff));
		op_queue.push_back(make_op(msa_pkg::KIND_NONE, 3'd0, 32'h1234_5678));
		op_queue.push_back(make_op(msa_pkg::KIND_NONE, 3'd5, 32'd0));
		for (k = 0; k < 5; k++)
			op_queue.push_back(make_op(msa_pkg::KIND_POP, 3'd0, 32'd0));
		wait_idle();

		// Directed: count above range clamps to eight; fill the last stack past its end
		write_stack_count(4'd9);
		for (k = 0; k < 9; k++)
			op_queue.push_back(make_op(msa_pkg::KIND_PUSH, 3'd7, $urandom()));
		op_queue.push_back(make_op(msa_pkg::KIND_LIST, 3'd7, 32'd0));
		wait_idle();

		// Random phases, each writing a stack count and setting the idle pattern for that phase
		for (p = 0; p < 6; p++) begin
			case (p)
				0: cnt = 4'd15;
				1: cnt = 4'd3;
				2: cnt = 4'd0;
				3: cnt = 4'd5;
				4: cnt = 4'd7;
				default: cnt = 4'd1;
			endcase
			snd_idle <= (p < 2) ? 24 : ((p < 4) ? 87 : 0);
			rcv_idle <= (p < 2) ? 87 : ((p < 4) ? 24 : 0);
			write_stack_count(cnt);
			seg = TOTAL_ENTRIES / stacks_n;
			made = 0;
			while (made < PHASE_OPS) begin
				roll = $urandom_range(0, 99);
				if (roll < 6) begin
					// Push one stack past full, then list it
					sn  = $urandom_range(0, stacks_n - 1);
					cap = (sn + 1 == stacks_n) ? TOTAL_ENTRIES - seg * sn : seg;
					for (k = 0; k <= cap; k++)
						op_queue.push_back(make_op(msa_pkg::KIND_PUSH, 3'(sn), $urandom()));
					op_queue.push_back(make_op(msa_pkg::KIND_LIST, 3'(sn), $urandom()));
					made += cap + 2;
				end else if (roll < 76) begin
					// Well-formed op on a stack that exists
					sn   = $urandom_range(0, stacks_n - 1);
					roll = $urandom_range(0, 99);
					op = make_op((roll < 50) ? msa_pkg::KIND_PUSH :
						((roll < 82) ? msa_pkg::KIND_POP : msa_pkg::KIND_LIST),
						3'(sn), $urandom());
					op_queue.push_back(op);
					made++;
				end else begin
					// Noise: any kind, any stack number
					op = make_op(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), $urandom());
					op_queue.push_back(op);
					if (op.kind != msa_pkg::KIND_NONE)
						made++;
				end
			end
			// Stall the reply side long enough to back up the input
			if (p == 1) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			wait_idle();
		end

		if (err_count == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
